// ===== sv/sd_card_spi_responder_assert.svh =====
// Assertion macros for the SD card SPI responder.
// Each macro names the clock aclk and the active-low reset aresetn of the module using it.
`ifndef SD_CARD_SPI_RESPONDER_ASSERT_SVH
`define SD_CARD_SPI_RESPONDER_ASSERT_SVH
`ifndef SYNTHESIS
`define SDSPI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdspi assertion failed");
`define SDSPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdspi assertion failed");
`else
`define SDSPI_ASSERT_SAME(label, ante, cons)
`define SDSPI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/sdspi_pkg.sv =====
`default_nettype none
package sdspi_pkg;

    // Sequencer states of the responder.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LIST,
        S_SEC,
        S_CRC_HI,
        S_CRC_LO,
        S_POP,
        S_POPW
    } state_t;

    // Fixed response lists.
    typedef enum logic [2:0] {
        LIST_CMD0,
        LIST_CMD8,
        LIST_CMD55,
        LIST_ACMD41,
        LIST_CMD58,
        LIST_SECTOR_HDR
    } list_t;

    // Request from the sequencer to the response FIFO.
    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       pop;
    } fifo_req_t;

    // Command frames, first byte in the top bits.
    localparam logic [47:0] PAT_CMD0   = 48'h40_00_00_00_00_95;
    localparam logic [47:0] PAT_CMD8   = 48'h48_00_00_01_AA_87;
    localparam logic [47:0] PAT_CMD55  = 48'h77_00_00_00_00_01;
    localparam logic [47:0] PAT_ACMD41 = 48'h69_40_00_00_00_01;
    localparam logic [47:0] PAT_CMD58  = 48'h7A_00_00_00_00_01;
    localparam logic [7:0]  CMD17_OP   = 8'h51;
    localparam logic [7:0]  CMD17_END  = 8'h01;
    localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam int unsigned SECTOR_BYTES = 512;

    // Number of bytes in a response list.
    function automatic logic [2:0] list_len(input list_t l);
        logic [2:0] n;
        unique case (l)
            LIST_CMD8, LIST_CMD58: n = 3'd6;
            LIST_SECTOR_HDR:       n = 3'd7;
            default:               n = 3'd2;
        endcase
        return n;
    endfunction

    // One byte of a response list.
    function automatic logic [7:0] list_byte(input list_t l, input logic [2:0] i);
        logic [7:0] b;
        b = 8'hFF;
        unique case (l)
            LIST_CMD0, LIST_CMD55: if (i == 3'd1) b = 8'h01;
            LIST_ACMD41:           if (i == 3'd1) b = 8'h00;
            LIST_CMD8: begin
                unique case (i)
                    3'd1:    b = 8'h01;
                    3'd2:    b = 8'h00;
                    3'd3:    b = 8'h00;
                    3'd4:    b = 8'h01;
                    3'd5:    b = 8'hAA;
                    default: b = 8'hFF;
                endcase
            end
            LIST_CMD58: begin
                unique case (i)
                    3'd1:    b = 8'h00;
                    3'd2:    b = 8'hC0;
                    3'd3:    b = 8'hFF;
                    3'd4:    b = 8'h80;
                    3'd5:    b = 8'h00;
                    default: b = 8'hFF;
                endcase
            end
            LIST_SECTOR_HDR: begin
                if (i == 3'd1) b = 8'h00;
                else if (i == 3'd6) b = 8'hFE;
            end
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

    // CRC16-XMODEM update over one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int j = 0; j < 8; j++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sdspi_fifo.sv =====
`default_nettype none
module sdspi_fifo
    import sdspi_pkg::*;
#(
    parameter int FIFO_DEPTH = 2048
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire fifo_req_t req,
    output logic           nonempty,
    output logic [7:0]     pop_data
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);
    localparam logic [FW-1:0] FULL = FW'(FIFO_DEPTH);

    logic [7:0]    mem [FIFO_DEPTH];
    logic [PW-1:0] head_reg, tail_reg;
    logic [FW-1:0] fill_reg;
    logic          do_push;

    // A byte offered while full is dropped.
    assign do_push  = req.push && (fill_reg != FULL);
    assign nonempty = (fill_reg != '0);

    // Storage: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[tail_reg] <= req.push_data;
        end
        if (req.pop) begin
            pop_data <= mem[head_reg];
        end
    end

    // Pointers and fill count. Pushes and pops never share a cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (do_push) begin
                tail_reg <= (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end else if (req.pop) begin
                head_reg <= (head_reg == LAST) ? '0 : head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/sd_card_spi_responder.sv =====
// SD card responder in SPI mode.
// Input beats on s_t*: s_tuser selects the kind. With s_tuser low the beat is an SPI
// clock level update, and a rising edge samples MOSI and shifts one MISO bit.
// With s_tuser high the beat writes one byte of the card image.
// Every input beat gives exactly one output beat on m_t*, carrying the current MISO bit.
// An image write or a beat without a rising edge is answered directly from S_IDLE;
// a rising edge passes through S_POP, and S_POPW as well when a FIFO byte is fetched.
// A completed command first pushes its response bytes in S_LIST; a sector read pushes
// 7 header bytes, then the 512 sector bytes read from the image in S_SEC, and 2 CRC
// bytes in S_CRC_HI and S_CRC_LO. A command that matches nothing pushes no bytes.
// One beat is in work at a time; s_tready drops while the sequencer runs.
// The output register lets a new beat in during the cycle its result is taken.
// If m_tready is held low, the result waits in the output register and no new beat
// is taken. Reset clears the SPI state and empties the response FIFO; the card
// image and FIFO storage keep whatever they hold.
`default_nettype none
module sd_card_spi_responder
    import sdspi_pkg::*;
#(
    parameter int SECTOR_COUNT = 16,
    parameter int FIFO_DEPTH   = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // clk_level, mosi, image_address[12:0], image_byte[7:0]
    input  wire logic [0:0]  s_tuser,  // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata   // miso
);

`include "sd_card_spi_responder_assert.svh"

    localparam longint IMAGE_BYTES = longint'(SECTOR_COUNT) * SECTOR_BYTES;
    localparam int IMG_DEPTH = (IMAGE_BYTES < 8192) ? int'(IMAGE_BYTES) : 8192;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int SEC_W     = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;

    // Input fields.
    logic        in_action, in_clk, in_mosi;
    logic [12:0] in_addr;
    logic [7:0]  in_byte;
    assign in_action = s_tuser[0];
    assign in_clk    = s_tdata[0];
    assign in_mosi   = s_tdata[1];
    assign in_addr   = s_tdata[14:2];
    assign in_byte   = s_tdata[22:15];

    state_t          state_reg, state_next;
    list_t           list_reg, list_next;
    logic [2:0]      lidx_reg, lidx_next;
    logic [9:0]      sidx_reg, sidx_next;
    logic            pend_reg, pend_next;
    logic [15:0]     crc_reg, crc_next;
    logic [SEC_W-1:0] sector_reg, sector_next;
    logic            last_clk_reg, last_clk_next;
    logic [7:0]      rx_shift_reg, rx_shift_next;
    logic [2:0]      rx_bits_reg, rx_bits_next;
    logic [7:0]      cmd_reg [6];
    logic [7:0]      cmd_next [6];
    logic [2:0]      cmd_cnt_reg, cmd_cnt_next;
    logic [7:0]      tx_reg, tx_next;
    logic [3:0]      tx_left_reg, tx_left_next;
    logic            miso_reg, miso_next;
    logic            m_valid_reg, m_valid_next;

    fifo_req_t       fifo_req;
    logic            fifo_nonempty;
    logic [7:0]      fifo_data;

    logic [7:0]      img_mem [IMG_DEPTH];
    logic [7:0]      img_rdata;
    logic            img_we, img_re;
    logic [IMG_AW-1:0] img_raddr;

    logic            fire;
    logic [7:0]      rx_byte;
    logic [47:0]     frame;
    logic [31:0]     sector32;
    logic [SEC_W+8:0] raddr_full;

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign fire     = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, miso_reg};

    assign rx_byte    = {rx_shift_reg[6:0], in_mosi};
    assign frame      = {cmd_reg[0], cmd_reg[1], cmd_reg[2], cmd_reg[3], cmd_reg[4], rx_byte};
    assign sector32   = {cmd_reg[1], cmd_reg[2], cmd_reg[3], cmd_reg[4]};
    assign raddr_full = {sector_reg, sidx_reg[8:0]};
    assign img_raddr  = raddr_full[IMG_AW-1:0];

    // Card image memory: written by image beats, read during a sector fill.
    always_ff @(posedge aclk) begin
        if (img_we) begin
            img_mem[in_addr[IMG_AW-1:0]] <= in_byte;
        end
        if (img_re) begin
            img_rdata <= img_mem[img_raddr];
        end
    end

    sdspi_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (fifo_req),
        .nonempty (fifo_nonempty),
        .pop_data (fifo_data)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            last_clk_reg <= 1'b0;
            rx_shift_reg <= '0;
            rx_bits_reg  <= '0;
            cmd_cnt_reg  <= '0;
            tx_reg       <= '0;
            tx_left_reg  <= '0;
            miso_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_clk_reg <= last_clk_next;
            rx_shift_reg <= rx_shift_next;
            rx_bits_reg  <= rx_bits_next;
            cmd_cnt_reg  <= cmd_cnt_next;
            tx_reg       <= tx_next;
            tx_left_reg  <= tx_left_next;
            miso_reg     <= miso_next;
            m_valid_reg  <= m_valid_next;
            pend_reg     <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        list_reg   <= list_next;
        lidx_reg   <= lidx_next;
        sidx_reg   <= sidx_next;
        crc_reg    <= crc_next;
        sector_reg <= sector_next;
        cmd_reg    <= cmd_next;
    end

    // Sequencer: receive, command decode, response fill, then MISO shift.
    always_comb begin
        state_next    = state_reg;
        list_next     = list_reg;
        lidx_next     = lidx_reg;
        sidx_next     = sidx_reg;
        pend_next     = pend_reg;
        crc_next      = crc_reg;
        sector_next   = sector_reg;
        last_clk_next = last_clk_reg;
        rx_shift_next = rx_shift_reg;
        rx_bits_next  = rx_bits_reg;
        cmd_next      = cmd_reg;
        cmd_cnt_next  = cmd_cnt_reg;
        tx_next       = tx_reg;
        tx_left_next  = tx_left_reg;
        miso_next     = miso_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        fifo_req      = '0;
        img_we        = 1'b0;
        img_re        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (fire) begin
                    if (in_action) begin
                        img_we       = (longint'(in_addr) < IMAGE_BYTES);
                        m_valid_next = 1'b1;
                    end else begin
                        last_clk_next = in_clk;
                        if (!last_clk_reg && in_clk) begin
                            state_next = S_POP;
                            if (rx_bits_reg == 3'd7) begin
                                rx_bits_next  = '0;
                                rx_shift_next = '0;
                                if (!(cmd_cnt_reg == 3'd0 && rx_byte == IDLE_BYTE)) begin
                                    cmd_next[cmd_cnt_reg] = rx_byte;
                                    cmd_cnt_next = cmd_cnt_reg + 3'd1;
                                    if (cmd_cnt_reg == 3'd5) begin
                                        cmd_cnt_next = '0;
                                        lidx_next    = '0;
                                        sector_next  = sector32[SEC_W-1:0];
                                        priority if (frame == PAT_CMD0) begin
                                            list_next = LIST_CMD0;
                                            state_next = S_LIST;
                                        end else if (frame == PAT_CMD8) begin
                                            list_next = LIST_CMD8;
                                            state_next = S_LIST;
                                        end else if (frame == PAT_CMD55) begin
                                            list_next = LIST_CMD55;
                                            state_next = S_LIST;
                                        end else if (frame == PAT_ACMD41) begin
                                            list_next = LIST_ACMD41;
                                            state_next = S_LIST;
                                        end else if (frame == PAT_CMD58) begin
                                            list_next = LIST_CMD58;
                                            state_next = S_LIST;
                                        end else if (cmd_reg[0] == CMD17_OP &&
                                                     rx_byte == CMD17_END &&
                                                     longint'(sector32) < longint'(SECTOR_COUNT)) begin
                                            list_next = LIST_SECTOR_HDR;
                                            state_next = S_LIST;
                                        end else begin
                                            state_next = S_POP;
                                        end
                                    end
                                end
                            end else begin
                                rx_bits_next  = rx_bits_reg + 3'd1;
                                rx_shift_next = rx_byte;
                            end
                        end else begin
                            m_valid_next = 1'b1;
                        end
                    end
                end
            end

            // Fixed response bytes, one per cycle.
            S_LIST: begin
                fifo_req.push      = 1'b1;
                fifo_req.push_data = list_byte(list_reg, lidx_reg);
                lidx_next          = lidx_reg + 3'd1;
                if (lidx_reg == list_len(list_reg) - 3'd1) begin
                    lidx_next = '0;
                    if (list_reg == LIST_SECTOR_HDR) begin
                        state_next = S_SEC;
                        sidx_next  = '0;
                        pend_next  = 1'b0;
                        crc_next   = '0;
                    end else begin
                        state_next = S_POP;
                    end
                end
            end

            // Sector fill: read one image byte per cycle and push it on the cycle after its read.
            S_SEC: begin
                if (pend_reg) begin
                    fifo_req.push      = 1'b1;
                    fifo_req.push_data = img_rdata;
                    crc_next           = crc_byte(crc_reg, img_rdata);
                end
                if (sidx_reg == 10'(SECTOR_BYTES)) begin
                    pend_next  = 1'b0;
                    state_next = S_CRC_HI;
                end else begin
                    img_re    = 1'b1;
                    pend_next = 1'b1;
                    sidx_next = sidx_reg + 10'd1;
                end
            end

            S_CRC_HI: begin
                fifo_req.push      = 1'b1;
                fifo_req.push_data = crc_reg[15:8];
                state_next         = S_CRC_LO;
            end

            S_CRC_LO: begin
                fifo_req.push      = 1'b1;
                fifo_req.push_data = crc_reg[7:0];
                state_next         = S_POP;
            end

            // Shift one MISO bit, loading a new byte when the last one is spent.
            S_POP: begin
                if (tx_left_reg == 4'd0) begin
                    if (fifo_nonempty) begin
                        fifo_req.pop = 1'b1;
                        state_next   = S_POPW;
                    end else begin
                        miso_next    = 1'b1;
                        tx_next      = 8'hFE;
                        tx_left_next = 4'd7;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    miso_next    = tx_reg[7];
                    tx_next      = {tx_reg[6:0], 1'b0};
                    tx_left_next = tx_left_reg - 4'd1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_POPW: begin
                miso_next    = fifo_data[7];
                tx_next      = {fifo_data[6:0], 1'b0};
                tx_left_next = 4'd7;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // A taken beat is either answered or still in work on the next cycle.
    `SDSPI_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, m_valid_reg || state_reg != S_IDLE)
    // No result is shown while the sequencer still works on a beat.
    `SDSPI_ASSERT_SAME(a_no_early_result, state_reg != S_IDLE, !m_valid_reg)
    // A pending image read exists only inside a sector fill.
    `SDSPI_ASSERT_SAME(a_pend_in_sector, pend_reg, state_reg == S_SEC || state_reg == S_CRC_HI)
    // The transmit bit count never exceeds one byte.
    `SDSPI_ASSERT_SAME(a_tx_left_range, 1'b1, tx_left_reg <= 4'd8)

endmodule
`default_nettype wire

// ===== tb/sd_card_spi_responder_chk.sv =====
`default_nettype none
module sd_card_spi_responder_chk
    import sdspi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,  // clk_level, mosi, image_address[12:0], image_byte[7:0]
    input  wire logic [0:0]  s_tuser,  // action
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,  // miso
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SECTORS     = 16;
    localparam int IMAGE_BYTES = SECTORS * SECTOR_BYTES;
    localparam int QUEUE_DEPTH = 2048;

    // Shadow copy of the card.
    logic        spi_level;
    logic [7:0]  rx_byte;
    int          rx_count;
    logic [7:0]  frame_bytes [6];
    int          frame_count;
    logic [7:0]  tx_byte;
    int          tx_count;
    logic        miso_now;
    logic [7:0]  response_bytes [$];
    logic [7:0]  image_mem [IMAGE_BYTES];

    // MISO bits owed to the host, oldest first.
    logic        miso_due [$];

    task report(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        errors++;
    endtask

    task queue_byte(input logic [7:0] b);
        if (response_bytes.size() < QUEUE_DEPTH) response_bytes.push_back(b);
    endtask

    task queue_sector(input logic [31:0] sector);
        logic [15:0] crc;
        logic [7:0]  b;
        int          base;
        crc = 16'h0000;
        if (sector < SECTORS) begin
            // Wait, accept, more wait bytes, then the start token.
            queue_byte(8'hFF);
            queue_byte(8'h00);
            repeat (4) queue_byte(8'hFF);
            queue_byte(8'hFE);
            base = int'(sector) * SECTOR_BYTES;
            for (int i = 0; i < SECTOR_BYTES; i++) begin
                b = image_mem[base + i];
                queue_byte(b);
                crc = crc ^ {b, 8'h00};
                for (int j = 0; j < 8; j++)
                    crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
            end
            queue_byte(crc[15:8]);
            queue_byte(crc[7:0]);
        end
    endtask

    task take_command_byte(input logic [7:0] b);
        logic [47:0] frame;
        if (!(frame_count == 0 && b == IDLE_BYTE)) begin
            frame_bytes[frame_count] = b;
            frame_count++;
            if (frame_count == 6) begin
                frame_count = 0;
                frame = {frame_bytes[0], frame_bytes[1], frame_bytes[2],
                         frame_bytes[3], frame_bytes[4], frame_bytes[5]};
                if (frame == PAT_CMD0 || frame == PAT_CMD55) begin
                    queue_byte(8'hFF); queue_byte(8'h01);
                end else if (frame == PAT_CMD8) begin
                    queue_byte(8'hFF); queue_byte(8'h01); queue_byte(8'h00);
                    queue_byte(8'h00); queue_byte(8'h01); queue_byte(8'hAA);
                end else if (frame == PAT_ACMD41) begin
                    queue_byte(8'hFF); queue_byte(8'h00);
                end else if (frame == PAT_CMD58) begin
                    queue_byte(8'hFF); queue_byte(8'h00); queue_byte(8'hC0);
                    queue_byte(8'hFF); queue_byte(8'h80); queue_byte(8'h00);
                end else if (frame[47:40] == CMD17_OP && frame[7:0] == CMD17_END) begin
                    queue_sector(frame[39:8]);
                end
            end
        end
    endtask

    // Advance the shadow card by one accepted input beat.
    task predict_beat(input logic act, input logic [23:0] d);
        if (act) begin
            if (int'(d[14:2]) < IMAGE_BYTES) image_mem[d[14:2]] = d[22:15];
        end else begin
            if (!spi_level && d[0]) begin
                rx_byte = {rx_byte[6:0], d[1]};
                rx_count++;
                if (rx_count == 8) begin
                    rx_count = 0;
                    take_command_byte(rx_byte);
                    rx_byte = 8'h00;
                end
                if (tx_count == 0) begin
                    tx_byte  = (response_bytes.size() > 0) ? response_bytes.pop_front() : 8'hFF;
                    tx_count = 8;
                end
                miso_now = tx_byte[7];
                tx_byte  = {tx_byte[6:0], 1'b0};
                tx_count--;
            end
            spi_level = d[0];
        end
        miso_due.push_back(miso_now);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            errors      = 0;
            spi_level   = 1'b0;
            rx_byte     = 8'h00;
            rx_count    = 0;
            frame_count = 0;
            tx_byte     = 8'h00;
            tx_count    = 0;
            miso_now    = 1'b0;
            response_bytes.delete();
            miso_due.delete();
        end else begin
            if (s_tvalid && s_tready) predict_beat(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) begin
                if (miso_due.size() == 0) begin
                    report($sformatf("result beat 0x%02h with nothing expected", m_tdata));
                end else if (m_tdata !== {7'b0, miso_due[0]}) begin
                    report($sformatf("miso beat 0x%02h, expected %0b", m_tdata, miso_due[0]));
                    void'(miso_due.pop_front());
                end else begin
                    void'(miso_due.pop_front());
                end
            end
        end
        pending = miso_due.size();
    end

endmodule
`default_nettype wire

// ===== tb/sd_card_spi_responder_tb.sv =====
`default_nettype none
module sd_card_spi_responder_tb
    import sdspi_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;  // clk_level, mosi, image_address[12:0], image_byte[7:0]
    logic [0:0]  s_tuser;  // action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;  // miso
    int          errors;
    int          pending;

    // Host-side view of the link, used to frame commands.
    logic        host_level;
    int          host_bits;
    logic [7:0]  host_shift;
    int          host_frame;
    int          beats;
    logic        calm;
    int          out_stall = 0;

    sd_card_spi_responder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sd_card_spi_responder_chk checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Safety net in case the block hangs.
    initial begin
        #8ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side back-pressure in random bursts.
    always @(posedge aclk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            m_tready  <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            out_stall <= $urandom_range(1, 18) - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= 1'b1;
        end
    end

    task note_edge(input logic b);
        host_shift = {host_shift[6:0], b};
        host_bits++;
        if (host_bits == 8) begin
            host_bits = 0;
            if (!(host_frame == 0 && host_shift == IDLE_BYTE)) host_frame = (host_frame + 1) % 6;
        end
    endtask

    // One input beat, with an optional idle burst in front of it.
    task send_beat(input logic act, input logic lvl, input logic bit_in,
                   input logic [12:0] adr, input logic [7:0] val);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, val, adr, bit_in, lvl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats++;
        if (!act) begin
            if (!host_level && lvl) note_edge(bit_in);
            host_level = lvl;
        end
    endtask

    task write_image(input logic [12:0] adr, input logic [7:0] val);
        send_beat(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), adr, val);
    endtask

    task spi_edge(input logic b);
        send_beat(1'b0, 1'b0, 1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191)),
                  8'($urandom_range(0, 255)));
        send_beat(1'b0, 1'b1, b, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
    endtask

    task spi_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--) spi_edge(b[i]);
    endtask

    // Bring the host back to a byte and frame boundary.
    task realign;
        while (host_bits != 0) spi_edge(1'b0);
        while (host_frame != 0) spi_byte(8'h00);
    endtask

    task spi_command(input logic [47:0] frame);
        realign();
        if ($urandom_range(0, 3) == 0) spi_byte(IDLE_BYTE);
        for (int i = 5; i >= 0; i--) spi_byte(frame[i*8 +: 8]);
    endtask

    function automatic logic [47:0] read_frame(input logic [31:0] sector);
        return {CMD17_OP, sector, CMD17_END};
    endfunction

    initial begin
        logic [47:0] junk;
        int          pick;
        int          stop_at;
        int          waited;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        host_level = 1'b0;
        host_bits  = 0;
        host_shift = 8'h00;
        host_frame = 0;
        beats      = 0;
        calm       = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the last sector, the only one ever read.
        for (int i = 0; i < SECTOR_BYTES; i++) begin
            write_image(13'(15 * SECTOR_BYTES + i), 8'($urandom_range(0, 255)));
        end
        write_image(13'd0, 8'hFF);
        write_image(13'd8191, 8'h00);

        // Directed: level-only updates, then the corner cases of a sector read.
        send_beat(1'b0, 1'b0, 1'b1, 13'h1FFF, 8'hFF);
        send_beat(1'b0, 1'b1, 1'b1, 13'h0000, 8'h00);
        send_beat(1'b0, 1'b1, 1'b0, 13'h1FFF, 8'hFF);
        spi_byte(IDLE_BYTE);
        spi_command(48'h51_00_00_00_00_02);
        spi_command(48'h12_34_56_78_9A_BC);
        spi_command(read_frame(32'd16));
        spi_command(read_frame(32'hFFFF_FFFF));
        spi_command(read_frame(32'd15));

        // Random traffic, mostly well-formed commands.
        stop_at = beats + 400;
        while (beats < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) spi_command(PAT_CMD0);
            else if (pick < 20) spi_command(PAT_CMD8);
            else if (pick < 28) spi_command(PAT_CMD55);
            else if (pick < 36) spi_command(PAT_ACMD41);
            else if (pick < 44) spi_command(PAT_CMD58);
            else if (pick < 47) spi_command(read_frame(32'd15));
            else if (pick < 52) spi_command(read_frame($urandom() | 32'h10));
            else if (pick < 57) begin
                junk = read_frame(32'd15);
                junk[7:0] = 8'($urandom_range(2, 255));
                spi_command(junk);
            end else if (pick < 64) begin
                spi_command({$urandom(), 16'($urandom())});
            end else if (pick < 74) begin
                write_image(13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
            end else if (pick < 84) begin
                repeat ($urandom_range(1, 4)) spi_byte(IDLE_BYTE);
            end else if (pick < 92) begin
                send_beat(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 7)) spi_edge(1'($urandom_range(0, 1)));
            end
        end

        // Last part without idling: overrun the response queue with sector reads.
        calm = 1'b1;
        repeat (4) spi_command(read_frame(32'd15));
        spi_command(PAT_CMD58);
        repeat (2) spi_byte(IDLE_BYTE);
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (600) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
